@@ rtl/pdbfc_pkg.sv @@
package pdbfc_pkg;

   localparam int PIXEL_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int FIELD_BITS = 16;
   localparam int MEAN_BITS = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int OUT_BITS = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CSR_DARK_ENABLE,
      CSR_BIAS_ENABLE,
      CSR_FLAT_ENABLE,
      CSR_FLAT_MEAN
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] light_value;
      logic [FIELD_BITS-1:0] dark_value;
      logic [FIELD_BITS-1:0] bias_value;
      logic [FIELD_BITS-1:0] flat_value;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] calibrated_value;
      logic flat_zero;
      logic saturated;
   } rsp_type;

   // per-item classification handed from front to back
   typedef struct packed {
      logic neg;
      logic flat_zero;
   } item_flags_type;

endpackage

@@ rtl/pixel_dark_bias_flat_calibrate.sv @@
// Dark, bias and flat-field correction of one pixel per clock. A pixel set is
// taken at each clock edge with start high and busy low; busy stays low in
// normal use, so a new pixel may be issued every cycle. Each result appears
// on rsp_payload for exactly one cycle with rsp_valid high, in issue order.
// Each pixel passes the classify stage, the queue read, the multiply and the
// pipelined restoring divider, which resolves one quotient bit per stage
// over the full numerator width, then rounding and saturation. The receiver
// cannot hold results off, so it must take every strobed result. The user
// must see that configuration is written through the csr port only while
// no pixel is in flight; the block does not enforce this. flat_mean of zero
// acts as one.
module pixel_dark_bias_flat_calibrate #(
   parameter int PIXEL_BITS = pdbfc_pkg::PIXEL_BITS_DEFAULT,
   parameter int FRAC_BITS = pdbfc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  pdbfc_pkg::req_type req_payload,
   output logic rsp_valid,
   output pdbfc_pkg::rsp_type rsp_payload,
   input  logic csr_write_enable,
   input  pdbfc_pkg::csr_index_type csr_index,
   input  logic [pdbfc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import pdbfc_pkg::*;

   localparam int MAG_W = PIXEL_BITS + 1;
   localparam int FLAGS_W = $bits(item_flags_type);
   localparam int ENTRY_W = FLAGS_W + MAG_W + MEAN_BITS + PIXEL_BITS;

   logic front_valid;
   item_flags_type front_flags, back_flags;
   logic [MAG_W-1:0] front_mag, back_mag;
   logic [MEAN_BITS-1:0] front_mean, back_mean;
   logic [PIXEL_BITS-1:0] front_den, back_den;
   logic [ENTRY_W-1:0] push_data, pop_data;
   logic queue_full;
   logic back_valid;

   pdbfc_front #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_payload(req_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .busy(busy),
      .out_valid(front_valid),
      .out_flags(front_flags),
      .out_mag(front_mag),
      .out_mean(front_mean),
      .out_den(front_den)
   );

   assign push_data = {front_flags, front_mag, front_mean, front_den};

   pdbfc_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(front_valid),
      .push_data(push_data),
      .full(queue_full),
      .pop_valid(back_valid),
      .pop_data(pop_data)
   );

   assign {back_flags, back_mag, back_mean, back_den} = pop_data;

   pdbfc_back #(
      .PIXEL_BITS(PIXEL_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(back_valid),
      .in_flags(back_flags),
      .in_mag(back_mag),
      .in_mean(back_mean),
      .in_den(back_den),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload)
   );

   assign busy = queue_full;

endmodule

@@ rtl/pdbfc_front.sv @@
module pdbfc_front #(
   parameter int PIXEL_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  pdbfc_pkg::req_type req_payload,
   input  logic csr_write_enable,
   input  pdbfc_pkg::csr_index_type csr_index,
   input  logic [pdbfc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic busy,
   output logic out_valid,
   output pdbfc_pkg::item_flags_type out_flags,
   output logic [PIXEL_BITS:0] out_mag,
   output logic [pdbfc_pkg::MEAN_BITS-1:0] out_mean,
   output logic [PIXEL_BITS-1:0] out_den
);
   import pdbfc_pkg::*;

   localparam int DIFF_W = PIXEL_BITS + 2;
   localparam int MAG_W = PIXEL_BITS + 1;

   logic dark_enable_ff, dark_enable_in;
   logic bias_enable_ff, bias_enable_in;
   logic flat_enable_ff, flat_enable_in;
   logic [MEAN_BITS-1:0] flat_mean_ff, flat_mean_in;

   logic valid_ff, valid_in;
   item_flags_type flags_ff, flags_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [MEAN_BITS-1:0] mean_ff, mean_in;
   logic [PIXEL_BITS-1:0] den_ff, den_in;

   logic [31:0] light_w, dark_w, bias_w, flat_w;
   logic [PIXEL_BITS-1:0] light_pix, dark_pix, bias_pix, flat_pix;
   logic [DIFF_W-1:0] diff, diff_neg;

   always_comb begin
      dark_enable_in = dark_enable_ff;
      bias_enable_in = bias_enable_ff;
      flat_enable_in = flat_enable_ff;
      flat_mean_in = flat_mean_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DARK_ENABLE: dark_enable_in = csr_wdata[0];
            CSR_BIAS_ENABLE: bias_enable_in = csr_wdata[0];
            CSR_FLAT_ENABLE: flat_enable_in = csr_wdata[0];
            CSR_FLAT_MEAN:   flat_mean_in = csr_wdata[MEAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // low pixel bits of each field, zero extended when pixels are wider
   assign light_w = 32'(req_payload.light_value);
   assign dark_w = 32'(req_payload.dark_value);
   assign bias_w = 32'(req_payload.bias_value);
   assign flat_w = 32'(req_payload.flat_value);
   assign light_pix = light_w[PIXEL_BITS-1:0];
   assign dark_pix = dark_w[PIXEL_BITS-1:0];
   assign bias_pix = bias_w[PIXEL_BITS-1:0];
   assign flat_pix = flat_w[PIXEL_BITS-1:0];

   always_comb begin
      diff = {2'b00, light_pix}
           - (dark_enable_ff ? {2'b00, dark_pix} : '0)
           - (bias_enable_ff ? {2'b00, bias_pix} : '0);
      diff_neg = ~diff + DIFF_W'(1);
      flags_in.neg = diff[DIFF_W-1];
      flags_in.flat_zero = flat_enable_ff && (flat_pix == '0);
      mag_in = flags_in.neg ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
      // flat off or zero flat: divide by one so the back path is uniform
      if (flat_enable_ff && !flags_in.flat_zero) begin
         den_in = flat_pix;
         mean_in = (flat_mean_ff == '0) ? MEAN_BITS'(1) : flat_mean_ff;
      end else begin
         den_in = PIXEL_BITS'(1);
         mean_in = MEAN_BITS'(1);
      end
      valid_in = start && !busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_enable_ff <= 1'b0;
         bias_enable_ff <= 1'b0;
         flat_enable_ff <= 1'b0;
         flat_mean_ff <= MEAN_BITS'(1);
         valid_ff <= 1'b0;
      end else begin
         dark_enable_ff <= dark_enable_in;
         bias_enable_ff <= bias_enable_in;
         flat_enable_ff <= flat_enable_in;
         flat_mean_ff <= flat_mean_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      mag_ff <= mag_in;
      mean_ff <= mean_in;
      den_ff <= den_in;
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_mag = mag_ff;
   assign out_mean = mean_ff;
   assign out_den = den_ff;

endmodule

@@ rtl/pdbfc_queue.sv @@
module pdbfc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic full,
   output logic pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import pdbfc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic pop_valid_ff;
   logic [WIDTH-1:0] pop_data_ff;
   logic pop;

   // the back end never stalls, so any stored item leaves at once
   assign pop = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push_valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         pop_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[wr_ptr_ff] <= push_data;
      end
      pop_data_ff <= mem[rd_ptr_ff];
   end

   assign full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = pop_valid_ff;
   assign pop_data = pop_data_ff;

endmodule

@@ rtl/pdbfc_back.sv @@
module pdbfc_back #(
   parameter int PIXEL_BITS = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  pdbfc_pkg::item_flags_type in_flags,
   input  logic [PIXEL_BITS:0] in_mag,
   input  logic [pdbfc_pkg::MEAN_BITS-1:0] in_mean,
   input  logic [PIXEL_BITS-1:0] in_den,
   output logic rsp_valid,
   output pdbfc_pkg::rsp_type rsp_payload
);
   import pdbfc_pkg::*;

   localparam int P = PIXEL_BITS;
   localparam int MAG_W = PIXEL_BITS + 1;
   localparam int PROD_W = MAG_W + MEAN_BITS;
   localparam int NUM_W = PROD_W + FRAC_BITS;
   localparam int QW = (NUM_W + 1 > OUT_BITS + 1) ? NUM_W + 1 : OUT_BITS + 1;
   localparam logic [QW-1:0] POS_LIMIT = QW'(64'd2147483647);
   localparam logic [QW-1:0] NEG_LIMIT = QW'(64'd2147483648);

   // stage 0 is the product, stages 1..NUM_W one quotient bit each
   logic [NUM_W:0] valid_ff;
   logic [NUM_W-1:0] nq_ff [NUM_W+1];
   logic [P-1:0] rem_ff [NUM_W+1];
   logic [P-1:0] den_ff [NUM_W+1];
   item_flags_type flags_ff [NUM_W+1];

   logic [PROD_W-1:0] prod_in;

   logic round_valid_ff;
   logic [QW-1:0] q_ff, q_in;
   item_flags_type round_flags_ff;
   logic round_up;

   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign prod_in = in_mag * in_mean;

   always_ff @(posedge clock) begin
      nq_ff[0] <= NUM_W'(prod_in) << FRAC_BITS;
      rem_ff[0] <= '0;
      den_ff[0] <= in_den;
      flags_ff[0] <= in_flags;
   end

   for (genvar s = 1; s <= NUM_W; s++) begin : g_div
      logic [P:0] trial;
      logic take;
      logic [P:0] rem_sub;

      always_comb begin
         trial = {rem_ff[s-1], nq_ff[s-1][NUM_W-1]};
         take = (trial >= {1'b0, den_ff[s-1]});
         rem_sub = trial - {1'b0, den_ff[s-1]};
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= take ? rem_sub[P-1:0] : trial[P-1:0];
         nq_ff[s] <= {nq_ff[s-1][NUM_W-2:0], take};
         den_ff[s] <= den_ff[s-1];
         flags_ff[s] <= flags_ff[s-1];
      end
   end

   // round half away from zero on the magnitude
   assign round_up = ({rem_ff[NUM_W], 1'b0} >= {1'b0, den_ff[NUM_W]});
   assign q_in = QW'(nq_ff[NUM_W]) + QW'(round_up);

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      round_flags_ff <= flags_ff[NUM_W];
   end

   always_comb begin
      rsp_in.flat_zero = round_flags_ff.flat_zero;
      rsp_in.saturated = 1'b0;
      rsp_in.calibrated_value = '0;
      if (!round_flags_ff.flat_zero) begin
         if (round_flags_ff.neg) begin
            if (q_ff > NEG_LIMIT) begin
               rsp_in.saturated = 1'b1;
               rsp_in.calibrated_value = NEG_LIMIT[OUT_BITS-1:0];
            end else begin
               rsp_in.calibrated_value = OUT_BITS'(0) - q_ff[OUT_BITS-1:0];
            end
         end else begin
            if (q_ff > POS_LIMIT) begin
               rsp_in.saturated = 1'b1;
               rsp_in.calibrated_value = POS_LIMIT[OUT_BITS-1:0];
            end else begin
               rsp_in.calibrated_value = q_ff[OUT_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         round_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[NUM_W-1:0], in_valid};
         round_valid_ff <= valid_ff[NUM_W];
         rsp_valid_ff <= round_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/pdbfc_checker.sv @@
module pdbfc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input pdbfc_pkg::req_type req_payload,
   input logic rsp_valid,
   input pdbfc_pkg::rsp_type rsp_payload,
   input logic csr_write_enable,
   input pdbfc_pkg::csr_index_type csr_index,
   input logic [pdbfc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import pdbfc_pkg::*;

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // a zero flat never also reports clipping
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.flat_zero && rsp_payload.saturated))
      else $error("flat_zero and saturated together");

   // zero flat forces a zero pixel
   a_flat_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.flat_zero) |-> (rsp_payload.calibrated_value == '0))
      else $error("flat_zero with nonzero value");

   // clipped values sit at one of the two rails
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.saturated) |->
         (rsp_payload.calibrated_value == 32'sh7fffffff ||
          rsp_payload.calibrated_value == 32'sh80000000))
      else $error("saturated value off the rails");

   // with the receiver unable to stall, the block never pushes back
   a_no_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("busy raised although the back end never stalls");

endmodule

bind pixel_dark_bias_flat_calibrate pdbfc_checker u_checker (.*);
